[hw/rtl/bpskm_pkg.sv]
package bpskm_pkg;

    // Default frame size in bytes (sync word excluded, CRC byte included)
    localparam int FRAME_BYTES_DEF = 64;

    localparam int SYNC_BITS = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    // Wide enough to compare byte counts against any legal frame size
    localparam int LEN_CMP_W = 9;
    // The byte index field addresses at most this many payload bytes
    localparam int INDEX_SPAN = 64;

    localparam logic [7:0] PAD_BYTE = 8'h55;
    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [14:0] AMPLITUDE_RESET = 15'd15000;
    localparam logic [7:0]  SPS_RESET       = 8'd5;
    localparam logic [31:0] SYNC_RESET      = 32'h1ACF_FC1D;

    // Input command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_AMPLITUDE = 2'd0;
    localparam logic [1:0] CFG_SPS       = 2'd1;
    localparam logic [1:0] CFG_SYNC      = 2'd2;

    // Work kinds held in the queue
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Frame sections
    localparam logic [1:0] SEG_SYNC = 2'd0;
    localparam logic [1:0] SEG_PAY  = 2'd1;
    localparam logic [1:0] SEG_CRC  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] idx;
        logic [7:0] data;   // write data, or clamped length for a begin
    } q_item_t;

    typedef struct packed {
        logic [14:0] amplitude;
        logic [7:0]  sym_len;
        logic [31:0] sync_pattern;
    } cfg_t;

endpackage

[hw/rtl/sync_crc_frame_bpsk_modulator_unit.sv]
// Path: a sample tick word goes through the queue, the stage register (with the store
//   read), then the output register before it shows on the master side; writes and
//   begins give no word.
// Throughput: one input word per cycle while the master side keeps up; a stalled
//   master fills the 4-word queue, then s_tready drops.
// Reset (rst_n, async, active low): registers to defaults, store reads as zero,
//   text length zero, frame restarts at the first sync sample with the CRC cleared.
module sync_crc_frame_bpsk_modulator_unit #(
    parameter int FRAME_BYTES = bpskm_pkg::FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [5:0] byte_index, [13:6] data_byte,
                                   // [19:14] text_length, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_value (signed)
    output logic        m_tuser,   // [0] frame_start
    output logic        m_tlast,   // frame_last
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bpskm_pkg::*;

    // Configuration registers; write only while idle (the block does not enforce it).
    cfg_t cfg_reg, cfg_next;

    // Queue between the front (classify) and the back (modulate).
    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_AMPLITUDE: cfg_next.amplitude    = cfg_data[14:0];
                CFG_SPS:       cfg_next.sym_len      = cfg_data[7:0];
                CFG_SYNC:      cfg_next.sync_pattern = cfg_data;
                default:       cfg_next = cfg_reg;   // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude    <= AMPLITUDE_RESET;
            cfg_reg.sym_len      <= SPS_RESET;
            cfg_reg.sync_pattern <= SYNC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: takes words, drops dead commands and out-of-range writes,
    // clamps the text length, and queues the rest in order.
    bpskm_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: bit position / phase counters and payload store in the first
    // stage, bit selection, CRC fold and the output register in the second.
    bpskm_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // Front only stalls when the queue actually holds work for the back.
    a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("front stalled with an empty queue");

    // First and final sample of a frame can never be the same word.
    a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser && m_tlast))
        else $error("frame start and frame last on one word");

    // Every sample is plus or minus the configured amplitude.
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata == {1'b0, cfg_reg.amplitude}) ||
                      (m_tdata == (~{1'b0, cfg_reg.amplitude} + 16'd1))))
        else $error("sample is not +/- amplitude");
`endif

endmodule

[hw/rtl/bpskm_ram.sv]
module bpskm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bpskm_front.sv]
module bpskm_front #(
    parameter int FRAME_BYTES = bpskm_pkg::FRAME_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               q_valid,
    output bpskm_pkg::q_item_t q_item,
    input  logic               q_pop
);
    import bpskm_pkg::*;

    localparam int PAY_BYTES = FRAME_BYTES - 1;
    localparam logic [LEN_CMP_W-1:0] PAY_CMP = LEN_CMP_W'(PAY_BYTES);

    logic [5:0] idx;
    logic [7:0] data;
    logic [5:0] len;
    logic       keep;
    logic       push;
    q_item_t    item;

    q_item_t                fifo_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign idx  = s_tdata[5:0];
    assign data = s_tdata[13:6];
    assign len  = s_tdata[19:14];

    // Classify: drop out-of-range writes and unused commands here
    always_comb
    begin
        keep      = 1'b0;
        item.kind = KIND_TICK;
        item.idx  = idx;
        item.data = data;
        case (s_tuser)
            CMD_WRITE:
            begin
                keep      = ({3'b000, idx} < PAY_CMP);
                item.kind = KIND_WRITE;
            end
            CMD_BEGIN:
            begin
                keep      = 1'b1;
                item.kind = KIND_BEGIN;
                item.data = ({3'b000, len} > PAY_CMP) ? PAY_CMP[7:0] : {2'b00, len};
            end
            CMD_TICK:
            begin
                keep      = 1'b1;
                item.kind = KIND_TICK;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

[hw/rtl/bpskm_back.sv]
module bpskm_back #(
    parameter int FRAME_BYTES = bpskm_pkg::FRAME_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bpskm_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  bpskm_pkg::q_item_t q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);
    import bpskm_pkg::*;

    localparam int PAY_BYTES   = FRAME_BYTES - 1;
    localparam int FRAME_BITS  = SYNC_BITS + 8 * FRAME_BYTES;
    localparam int PAY_END     = SYNC_BITS + 8 * PAY_BYTES;
    localparam int POS_W       = $clog2(FRAME_BITS);
    localparam int STORE_DEPTH = (PAY_BYTES < INDEX_SPAN) ? PAY_BYTES : INDEX_SPAN;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // ---- stage A: position tracking, store write, store read issue ----
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [7:0]             phase_reg, phase_next;
    logic [5:0]             active_reg, active_next;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;

    logic [POS_W-1:0]  off;
    logic [ADDR_W-1:0] k_addr;
    logic              in_sync, in_pay, k_live, done, pop, s1_adv;
    logic [1:0]        seg;
    logic [4:0]        bitsel;
    logic [7:0]        ram_rdata;

    // ---- stage B inputs ----
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_kind_reg, s1_seg_reg;
    logic [4:0] s1_bitsel_reg;
    logic       s1_use_ram_reg, s1_done_reg, s1_start_reg, s1_last_reg;
    logic [7:0] s1_const_reg;

    logic [7:0]  crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg;
    logic        out_start_reg, out_last_reg;
    logic [7:0]  cur_byte;
    logic        bit_val;
    logic [15:0] amp16;

    assign off     = pos_reg - POS_W'(SYNC_BITS);
    assign in_sync = (pos_reg < POS_W'(SYNC_BITS));
    assign in_pay  = !in_sync && (pos_reg < POS_W'(PAY_END));
    assign seg     = in_sync ? SEG_SYNC : (in_pay ? SEG_PAY : SEG_CRC);
    assign bitsel  = in_sync ? ~pos_reg[4:0] : {2'b00, ~off[2:0]};
    assign k_addr  = off[ADDR_W+2:3];
    // byte live only below the active length; its store entry may be unwritten
    assign k_live  = in_pay && ((off >> 3) < POS_W'(active_reg));
    assign done    = ({1'b0, phase_reg} + 9'd1) >= {1'b0, cfg.sym_len};

    assign s1_adv = s1_valid_reg &&
                    (s1_kind_reg != KIND_TICK || !out_valid_reg || m_tready);
    assign pop    = q_valid && (!s1_valid_reg || s1_adv);
    assign q_pop  = pop;

    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        valid_next  = valid_reg;
        if (pop)
        begin
            case (q_item.kind)
                KIND_WRITE:
                begin
                    valid_next[q_item.idx[ADDR_W-1:0]] = 1'b1;
                end
                KIND_BEGIN:
                begin
                    active_next = q_item.data[5:0];
                    pos_next    = '0;
                    phase_next  = '0;
                end
                KIND_TICK:
                begin
                    if (done)
                    begin
                        phase_next = '0;
                        pos_next   = (pos_reg == POS_W'(FRAME_BITS - 1)) ? '0 : pos_reg + 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    bpskm_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (pop && q_item.kind == KIND_WRITE),
        .waddr (q_item.idx[ADDR_W-1:0]),
        .wdata (q_item.data),
        .re    (pop && q_item.kind == KIND_TICK),
        .raddr (k_addr),
        .rdata (ram_rdata)
    );

    assign s1_valid_next = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= '0;
            active_reg    <= '0;
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            valid_reg     <= valid_next;
            s1_valid_reg  <= s1_valid_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_kind_reg    <= q_item.kind;
            s1_seg_reg     <= seg;
            s1_bitsel_reg  <= bitsel;
            s1_use_ram_reg <= k_live && valid_reg[k_addr];
            s1_const_reg   <= k_live ? 8'h00 : PAD_BYTE;
            s1_done_reg    <= done;
            s1_start_reg   <= (pos_reg == '0) && (phase_reg == '0);
            s1_last_reg    <= done && (pos_reg == POS_W'(FRAME_BITS - 1));
        end
    end

    // ---- stage B: bit pick, CRC fold, sample out ----
    assign cur_byte = s1_use_ram_reg ? ram_rdata : s1_const_reg;
    assign amp16    = {1'b0, cfg.amplitude};

    always_comb
    begin
        case (s1_seg_reg)
            SEG_SYNC: bit_val = cfg.sync_pattern[s1_bitsel_reg];
            SEG_PAY:  bit_val = cur_byte[s1_bitsel_reg[2:0]];
            default:  bit_val = crc_reg[s1_bitsel_reg[2:0]];
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (s1_adv)
        begin
            if (s1_kind_reg == KIND_BEGIN)
            begin
                crc_next = '0;
            end
            else if (s1_kind_reg == KIND_TICK && s1_last_reg)
            begin
                // frame wraps: next frame's CRC starts from zero
                crc_next = '0;
            end
            else if (s1_kind_reg == KIND_TICK && s1_done_reg && s1_seg_reg == SEG_PAY)
            begin
                crc_next = {crc_reg[6:0], 1'b0} ^ ((crc_reg[7] ^ bit_val) ? CRC_POLY : 8'h00);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_kind_reg == KIND_TICK)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_kind_reg == KIND_TICK)
        begin
            out_data_reg  <= bit_val ? amp16 : (~amp16 + 16'd1);
            out_start_reg <= s1_start_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_start_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sim/sync_crc_frame_bpsk_modulator_unit_test.sv]
module sync_crc_frame_bpsk_modulator_unit_test;

    import bpskm_pkg::*;

    // Frame geometry for the default build: sync word, 63 payload bytes, CRC byte
    localparam int FRAME_LEN_BYTES = FRAME_BYTES_DEF;
    localparam int PAY_BYTES       = FRAME_LEN_BYTES - 1;
    localparam int PAY_END         = SYNC_BITS + 8 * PAY_BYTES;
    localparam int FRAME_BITS      = SYNC_BITS + 8 * FRAME_LEN_BYTES;

    // Command 3 has no meaning; the block must drop it silently
    localparam int unsigned CMD_SPARE_I = 3;
    localparam logic [1:0] CMD_SPARE = 2'(CMD_SPARE_I);

    // Queue plus two pipeline registers; a little margin for trailing writes/begins
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] idx;
        logic [7:0] data;
        logic [5:0] len;
    } word_t;

    typedef struct packed {
        logic [15:0] value;
        logic        start;
        logic        last;
    } sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_AMPLITUDE;
    logic [31:0] cfg_data = '0;

    // Stimulus and expected-sample stores
    word_t   stim_words[$];
    word_t   held_word = '0;
    sample_t pending_samples[$];

    // Modulator shadow state (mirrors reset values)
    logic [7:0]  payload_bytes [PAY_BYTES];
    logic [5:0]  text_len  = '0;
    logic [9:0]  bit_pos   = '0;
    logic [7:0]  tick_phase = '0;
    logic [7:0]  crc_acc   = '0;
    logic [14:0] amp_reg   = AMPLITUDE_RESET;
    logic [7:0]  sps_reg   = SPS_RESET;
    logic [31:0] sync_reg  = SYNC_RESET;

    // Handshake pressure, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int words_queued    = 0;
    int words_accepted  = 0;
    int samples_checked = 0;
    int frame_ends      = 0;
    int fail_count      = 0;
    int report_count    = 0;
    int quiet_cycles    = 0;

    sync_crc_frame_bpsk_modulator_unit #(
        .FRAME_BYTES(FRAME_LEN_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow modulator: applies one accepted word, queues the sample a tick yields
    function automatic void step_modulator(input word_t w);
        int      p;
        int      off;
        int      byte_idx;
        logic    bit_val;
        logic    done;
        logic    fb;
        logic [7:0] byte_val;
        sample_t s;
        p = int'(bit_pos);
        case (w.cmd)
            CMD_WRITE:
            begin
                // Index 63 falls past the payload and is dropped
                if (int'(w.idx) < PAY_BYTES)
                    payload_bytes[w.idx] = w.data;
            end
            CMD_BEGIN:
            begin
                text_len   = (int'(w.len) > PAY_BYTES) ? 6'(PAY_BYTES) : w.len;
                bit_pos    = '0;
                tick_phase = '0;
                crc_acc    = '0;
            end
            CMD_TICK:
            begin
                if (p < SYNC_BITS)
                    bit_val = sync_reg[31 - p];
                else if (p < PAY_END)
                begin
                    off      = p - SYNC_BITS;
                    byte_idx = off >> 3;
                    // Bytes beyond the text length go out as pad
                    byte_val = (byte_idx < int'(text_len)) ? payload_bytes[byte_idx]
                                                           : PAD_BYTE;
                    bit_val  = byte_val[7 - (off & 7)];
                end
                else
                    bit_val = crc_acc[7 - ((p - SYNC_BITS) & 7)];

                // Zero symbol length behaves as one; a shortened symbol ends at once
                done = (int'(tick_phase) + 1 >= int'(sps_reg));

                s.value = bit_val ? {1'b0, amp_reg} : 16'h0000 - {1'b0, amp_reg};
                s.start = (p == 0) && (tick_phase == 8'd0);
                s.last  = done && (p == FRAME_BITS - 1);
                pending_samples.push_back(s);

                if (done)
                begin
                    if (p >= SYNC_BITS && p < PAY_END)
                    begin
                        fb      = crc_acc[7] ^ bit_val;
                        crc_acc = {crc_acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
                    end
                    tick_phase = '0;
                    if (p + 1 >= FRAME_BITS)
                    begin
                        bit_pos = '0;
                        crc_acc = '0;
                    end
                    else
                        bit_pos = 10'(p + 1);
                end
                else
                    tick_phase = tick_phase + 8'd1;
            end
            default:
            begin
                // spare command: no effect
            end
        endcase
    endfunction

    // Driver: presents queued words, holds them under backpressure
    always @(posedge clk)
    begin : driver_proc
        word_t nw;
        if (s_tvalid && s_tready)
        begin
            // predict first so the drain check never sees a gap
            step_modulator(held_word);
            words_accepted++;
        end
        if (!s_tvalid || s_tready)
        begin
            if (rst_n && stim_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nw = stim_words.pop_front();
                held_word <= nw;
                s_tvalid  <= 1'b1;
                s_tdata   <= {4'b0000, nw.len, nw.data, nw.idx};
                s_tuser   <= nw.cmd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: every sample word against the oldest prediction
    always @(posedge clk)
    begin : monitor_proc
        sample_t want;
        if (m_tvalid && m_tready)
        begin
            if (m_tlast === 1'b1)
                frame_ends++;
            if (pending_samples.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("unexpected sample: value %0d start %b last %b",
                             $signed(m_tdata), m_tuser, m_tlast);
                end
            end
            else
            begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (m_tdata !== want.value || m_tuser !== want.start
                    || m_tlast !== want.last)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                    begin
                        report_count++;
                        $display("sample %0d mismatch: exp value %0d start %b last %b,",
                                 samples_checked, $signed(want.value), want.start,
                                 want.last);
                        $display("    got value %0d start %b last %b",
                                 $signed(m_tdata), m_tuser, m_tlast);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: no word moving on either side for too long means a hang
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_word(input logic [1:0] cmd, input logic [5:0] idx,
                             input logic [7:0] data, input logic [5:0] len);
        word_t w;
        w.cmd  = cmd;
        w.idx  = idx;
        w.data = data;
        w.len  = len;
        stim_words.push_back(w);
        words_queued++;
    endtask

    // Mostly ticks, with payload rewrites mid-frame and some noise.
    // All fields are random on every word so each bit toggles.
    task automatic queue_mix(input int count, input int begin_pct);
        int roll;
        logic [1:0] cmd;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < begin_pct)
                cmd = CMD_BEGIN;
            else if (roll < begin_pct + 6)
                cmd = CMD_WRITE;
            else if (roll < begin_pct + 8)
                cmd = CMD_SPARE;
            else
                cmd = CMD_TICK;
            push_word(cmd, 6'($urandom_range(63)), 8'($urandom_range(255)),
                      6'($urandom_range(63)));
        end
    endtask

    // Well-formed frame: begin, load some payload, then a long run of mostly ticks
    task automatic queue_frame(input int ticks);
        push_word(CMD_BEGIN, 6'($urandom_range(63)), 8'($urandom_range(255)),
                  6'($urandom_range(63)));
        repeat ($urandom_range(4, 16))
            push_word(CMD_WRITE, 6'($urandom_range(62)), 8'($urandom_range(255)),
                      6'($urandom_range(63)));
        queue_mix(ticks, 0);
    endtask

    // Block until every queued word is taken and every sample is back
    task automatic drain();
        while (words_accepted != words_queued || pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block drained
    task automatic set_config(input logic [14:0] amp, input logic [7:0] sps,
                              input logic [31:0] sync_val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_AMPLITUDE;
        cfg_data  <= {17'd0, amp};
        @(posedge clk);
        cfg_index <= CFG_SPS;
        cfg_data  <= {24'd0, sps};
        @(posedge clk);
        cfg_index <= CFG_SYNC;
        cfg_data  <= sync_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        amp_reg  = amp;
        sps_reg  = sps;
        sync_reg = sync_val;
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        foreach (payload_bytes[i])
            payload_bytes[i] = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset settings, no handshake pressure.
        // First tick must flag frame start; empty text -> all pad.
        push_word(CMD_TICK, 6'd0, 8'h00, 6'd0);
        push_word(CMD_WRITE, 6'd0, 8'hFF, 6'd0);
        push_word(CMD_WRITE, 6'd62, 8'h00, 6'd63);
        push_word(CMD_WRITE, 6'd63, 8'hA5, 6'd0);     // past the payload, dropped
        push_word(CMD_WRITE, 6'd1, 8'h81, 6'd0);
        push_word(CMD_SPARE, 6'd63, 8'hFF, 6'd63);    // no effect, no word out
        push_word(CMD_BEGIN, 6'd63, 8'hFF, 6'd63);    // full text length
        repeat (6)
            push_word(CMD_TICK, 6'd63, 8'hFF, 6'd63);
        push_word(CMD_BEGIN, 6'd0, 8'h00, 6'd0);      // empty text, restart
        push_word(CMD_TICK, 6'd0, 8'h00, 6'd0);
        push_word(CMD_BEGIN, 6'd0, 8'h00, 6'd2);
        repeat (7)
            push_word(CMD_TICK, 6'd0, 8'h00, 6'd0);
        drain();

        // Full amplitude, one sample per bit: run through a whole frame and
        // past the wrap, so the CRC byte and frame_last are exercised
        set_config(15'h7FFF, 8'd1, $urandom);
        queue_frame(600);
        drain();

        // Zero amplitude and zero symbol length, sender mostly idle
        send_idle_pct = 78;
        set_config(15'd0, 8'd0, 32'hFFFF_FFFF);
        queue_mix(120, 3);
        drain();

        // Receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        set_config(15'($urandom_range(32767)), 8'd3, 32'h0000_0000);
        queue_frame(150);
        drain();

        // Longest symbol; the run stops mid-bit so the next phase shortens it
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        set_config(15'($urandom_range(32767)), 8'd255, $urandom);
        queue_mix(80, 0);
        drain();

        // Short symbol with a large phase left over: that bit ends at once
        set_config(15'($urandom_range(32767)), 8'd2, $urandom);
        queue_mix(120, 2);
        drain();

        if (pending_samples.size() != 0)
        begin
            fail_count++;
            $display("%0d predicted samples never arrived", pending_samples.size());
        end

        $display("Sent %0d words, checked %0d samples, saw %0d frame ends;",
                 words_accepted, samples_checked, frame_ends);
        $display("amplitude 0..32767, symbol lengths 0..255, mid-frame rewrites.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bpskm_pkg.sv
hw/rtl/bpskm_ram.sv
hw/rtl/bpskm_front.sv
hw/rtl/bpskm_back.sv
hw/rtl/sync_crc_frame_bpsk_modulator_unit.sv
sim/sync_crc_frame_bpsk_modulator_unit_test.sv
